FILE: hw/rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants of the polygon signed distance unit
// Vertex table sizing, codes, stream widths and the square root stage record.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 48;

    // square root: radicand below 2^60, one result bit per cell
    localparam int ROOT_STEPS = 30;
    localparam int RAD_W      = 2 * ROOT_STEPS;
    localparam int ROOT_W     = ROOT_STEPS;

    localparam logic [ROOT_W-1:0] CAP_Q16 = 30'd655360000;
    // (10000.0 in Q18.14)^2
    localparam logic [63:0]       CAP_SQ  = 64'd26843545600000000;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [RAD_W-1:0]  v;
        logic [RAD_W-1:0]  r;
        logic [ADDR_W-1:0] si;
        logic [ADDR_W-1:0] ei;
    } root_stage_t;

endpackage

FILE: hw/rtl/psd_root_cell.sv
// ----------------------------------------------------------------------------
// psd_root_cell: one step of the digit-by-digit integer square root
// Tries one result bit, registers remainder, partial root and edge tags.
// ----------------------------------------------------------------------------
module psd_root_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [4:0]           bit_pos,
    input  psd_pkg::root_stage_t stage_in,
    output psd_pkg::root_stage_t stage_out
);
    import psd_pkg::*;

    logic [RAD_W-1:0] bit_val;
    logic [RAD_W-1:0] trial;
    root_stage_t      stage_next;
    root_stage_t      stage_reg;

    always_comb begin
        bit_val    = RAD_W'(1) << {bit_pos, 1'b0};
        trial      = stage_in.r + bit_val;
        stage_next = stage_in;
        if (stage_in.v >= trial) begin
            stage_next.v = stage_in.v - trial;
            stage_next.r = (stage_in.r >> 1) + bit_val;
        end else begin
            stage_next.r = stage_in.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else begin
            stage_reg.valid <= stage_in.valid;
        end
        stage_reg.v  <= stage_next.v;
        stage_reg.r  <= stage_next.r;
        stage_reg.si <= stage_next.si;
        stage_reg.ei <= stage_next.ei;
    end

    assign stage_out = stage_reg;

endmodule

FILE: hw/rtl/psd_root_chain.sv
// ----------------------------------------------------------------------------
// psd_root_chain: row of square root cells
// Each cell resolves one root bit and hands its record to the next each cycle.
// ----------------------------------------------------------------------------
module psd_root_chain (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  psd_pkg::root_stage_t chain_in,
    output psd_pkg::root_stage_t chain_out
);
    import psd_pkg::*;

    root_stage_t link [ROOT_STEPS+1];

    assign link[0] = chain_in;

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_cell
        psd_root_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .bit_pos   (5'(ROOT_STEPS - 1 - k)),
            .stage_in  (link[k]),
            .stage_out (link[k+1])
        );
    end

    assign chain_out = link[ROOT_STEPS];

endmodule

FILE: hw/rtl/polygon_signed_distance_unit.sv
// ----------------------------------------------------------------------------
// polygon_signed_distance_unit: signed distance from a point to a polygon
// Append: the status result is registered in ST_OUT. Query over N vertices:
// per edge a read, latch, differences, multiplies, a decision, the 16-step
// divide when the projection needs it, offsets, squares and a push into the
// square root cell row, which drains before the result. One transaction is
// worked at a time; the shared multiplier and the edge sequencer pace each
// edge. Reset clears vertex count and control, not the vertex table.
// ----------------------------------------------------------------------------
module polygon_signed_distance_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [psd_pkg::S_DATA_W-1:0]  s_tdata,   // x_coord, y_coord
    input  logic                          s_tuser,   // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psd_pkg::M_DATA_W-1:0]  m_tdata    // signed_distance, start_index,
                                                     // end_index, status, zero pad
);
    import psd_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE   = 16'h0001,
        ST_RDW    = 16'h0002,
        ST_LATCH  = 16'h0004,
        ST_DIFF   = 16'h0008,
        ST_MUL    = 16'h0010,
        ST_DECIDE = 16'h0020,
        ST_DIV    = 16'h0040,
        ST_OFFX   = 16'h0080,
        ST_OFFY   = 16'h0100,
        ST_OFFR   = 16'h0200,
        ST_SQX    = 16'h0400,
        ST_SQY    = 16'h0800,
        ST_SQS    = 16'h1000,
        ST_PUSH   = 16'h2000,
        ST_DRAIN  = 16'h4000,
        ST_OUT    = 16'h8000
    } state_t;

    state_t state_reg;

    logic [63:0]       mem [MAX_VERTICES];
    logic [63:0]       mem_q_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic signed [31:0] qx_reg, qy_reg;
    logic signed [31:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic               first_reg;
    logic [ADDR_W-1:0]  start_idx_reg;
    logic [CNT_W-1:0]   j_reg;

    logic signed [30:0] vx_reg, vy_reg, ux_reg, uy_reg;
    logic signed [32:0] lx_reg, dy_reg, sxe_reg, yey_reg;
    logic               cond_reg;
    logic [2:0]         mstep_reg;
    logic signed [63:0] len2_reg, dot_reg;
    logic signed [65:0] lhs_reg, rhs_reg;
    logic [63:0]        rem_reg;
    logic [15:0]        p_reg;
    logic [3:0]         div_cnt_reg;
    logic signed [32:0] rx_reg, ry_reg;
    logic [63:0]        d2_reg;
    logic [4:0]         drain_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    logic [ROOT_W-1:0]  best_reg;
    logic [ADDR_W-1:0]  best_si_reg, best_ei_reg;
    logic               inside_reg;

    logic               res_append_reg;
    status_t            res_status_reg;

    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    root_stage_t chain_in, chain_out;

    logic               s_fire;
    logic signed [31:0] in_x, in_y;
    logic signed [32:0] dvx, dvy, dux, duy;
    logic [63:0]        rem2;
    logic [CNT_W-1:0]   j_inc;
    logic [ROOT_W-1:0]  root;
    logic [30:0]        dist_out;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_x     = s_tdata[31:0];
    assign in_y     = s_tdata[63:32];
    assign j_inc    = j_reg + 1'b1;
    assign rem2     = {rem_reg[62:0], 1'b0};
    assign root     = chain_out.r[ROOT_W-1:0];

    // coordinate differences, floored to Q17.14 by dropping two bits
    always_comb begin
        dvx = {qx_reg[31], qx_reg} - {sx_reg[31], sx_reg};
        dvy = {qy_reg[31], qy_reg} - {sy_reg[31], sy_reg};
        dux = {ex_reg[31], ex_reg} - {sx_reg[31], sx_reg};
        duy = {ey_reg[31], ey_reg} - {sy_reg[31], sy_reg};
    end

    // vertex table
    always_ff @(posedge aclk) begin
        if (s_fire && s_tuser == OP_APPEND && count_reg < CNT_W'(MAX_VERTICES)) begin
            mem[count_reg[ADDR_W-1:0]] <= s_tdata;
        end
        mem_q_reg <= mem[rd_addr_reg];
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL: begin
                case (mstep_reg)
                    3'd0: begin mul_a = 33'(ux_reg); mul_b = 33'(ux_reg); end
                    3'd1: begin mul_a = 33'(uy_reg); mul_b = 33'(uy_reg); end
                    3'd2: begin mul_a = 33'(ux_reg); mul_b = 33'(vx_reg); end
                    3'd3: begin mul_a = 33'(uy_reg); mul_b = 33'(vy_reg); end
                    3'd4: begin mul_a = lx_reg;      mul_b = dy_reg;      end
                    3'd5: begin mul_a = sxe_reg;     mul_b = yey_reg;     end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_OFFX: begin mul_a = 33'(ux_reg); mul_b = $signed({17'b0, p_reg}); end
            ST_OFFY: begin mul_a = 33'(uy_reg); mul_b = $signed({17'b0, p_reg}); end
            ST_SQX:  begin mul_a = rx_reg; mul_b = rx_reg; end
            ST_SQY:  begin mul_a = ry_reg; mul_b = ry_reg; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        chain_in.valid = (state_reg == ST_PUSH) && (d2_reg < CAP_SQ);
        chain_in.v     = {d2_reg[RAD_W-5:0], 4'b0};
        chain_in.r     = '0;
        chain_in.si    = start_idx_reg;
        chain_in.ei    = j_reg[ADDR_W-1:0];
    end

    psd_root_chain u_root_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .chain_in  (chain_in),
        .chain_out (chain_out)
    );

    // edge sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the result register reloads in ST_OUT, so drop valid only elsewhere
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        qx_reg         <= in_x;
                        qy_reg         <= in_y;
                        res_status_reg <= STATUS_OK;
                        res_append_reg <= 1'b1;
                        best_reg       <= CAP_Q16;
                        best_si_reg    <= ADDR_W'(count_reg - 1'b1);
                        best_ei_reg    <= '0;
                        inside_reg     <= 1'b0;
                        first_reg      <= 1'b1;
                        start_idx_reg  <= ADDR_W'(count_reg - 1'b1);
                        j_reg          <= '0;
                        rd_addr_reg    <= ADDR_W'(count_reg - 1'b1);
                        if (s_tuser == OP_APPEND) begin
                            if (count_reg < CNT_W'(MAX_VERTICES)) begin
                                count_reg <= count_reg + 1'b1;
                            end else begin
                                res_status_reg <= STATUS_FULL;
                            end
                            state_reg <= ST_OUT;
                        end else if (count_reg == '0) begin
                            res_status_reg <= STATUS_EMPTY;
                            state_reg      <= ST_OUT;
                        end else begin
                            res_append_reg <= 1'b0;
                            state_reg      <= ST_RDW;
                        end
                    end
                end
                ST_RDW: begin
                    state_reg <= ST_LATCH;
                end
                ST_LATCH: begin
                    if (first_reg) begin
                        sx_reg      <= mem_q_reg[31:0];
                        sy_reg      <= mem_q_reg[63:32];
                        first_reg   <= 1'b0;
                        rd_addr_reg <= '0;
                        state_reg   <= ST_RDW;
                    end else begin
                        ex_reg    <= mem_q_reg[31:0];
                        ey_reg    <= mem_q_reg[63:32];
                        state_reg <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    vx_reg    <= dvx[32:2];
                    vy_reg    <= dvy[32:2];
                    ux_reg    <= dux[32:2];
                    uy_reg    <= duy[32:2];
                    // crossing test with i = edge end, j = edge start
                    lx_reg    <= {qx_reg[31], qx_reg} - {ex_reg[31], ex_reg};
                    dy_reg    <= {sy_reg[31], sy_reg} - {ey_reg[31], ey_reg};
                    sxe_reg   <= {sx_reg[31], sx_reg} - {ex_reg[31], ex_reg};
                    yey_reg   <= {qy_reg[31], qy_reg} - {ey_reg[31], ey_reg};
                    cond_reg  <= (ey_reg > qy_reg) != (sy_reg > qy_reg);
                    mstep_reg <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    mstep_reg <= mstep_reg + 1'b1;
                    case (mstep_reg)
                        3'd1: len2_reg <= prod_reg[63:0];
                        3'd2: len2_reg <= len2_reg + prod_reg[63:0];
                        3'd3: dot_reg  <= prod_reg[63:0];
                        3'd4: dot_reg  <= dot_reg + prod_reg[63:0];
                        3'd5: lhs_reg  <= prod_reg;
                        3'd6: rhs_reg  <= prod_reg;
                        default: ;
                    endcase
                    if (mstep_reg == 3'd6) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (cond_reg && ((dy_reg > 0) ? (lhs_reg < rhs_reg)
                                                  : (rhs_reg < lhs_reg))) begin
                        inside_reg <= !inside_reg;
                    end
                    if (len2_reg == 0 || dot_reg <= 0) begin
                        rx_reg    <= 33'(vx_reg);
                        ry_reg    <= 33'(vy_reg);
                        state_reg <= ST_SQX;
                    end else if (dot_reg >= len2_reg) begin
                        rx_reg    <= 33'(vx_reg) - 33'(ux_reg);
                        ry_reg    <= 33'(vy_reg) - 33'(uy_reg);
                        state_reg <= ST_SQX;
                    end else begin
                        rem_reg     <= dot_reg;
                        p_reg       <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rem2 >= len2_reg) begin
                        rem_reg <= rem2 - len2_reg;
                        p_reg   <= {p_reg[14:0], 1'b1};
                    end else begin
                        rem_reg <= rem2;
                        p_reg   <= {p_reg[14:0], 1'b0};
                    end
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 4'd15) begin
                        state_reg <= ST_OFFX;
                    end
                end
                ST_OFFX: begin
                    state_reg <= ST_OFFY;
                end
                ST_OFFY: begin
                    rx_reg    <= 33'(vx_reg) - prod_reg[48:16];
                    state_reg <= ST_OFFR;
                end
                ST_OFFR: begin
                    ry_reg    <= 33'(vy_reg) - prod_reg[48:16];
                    state_reg <= ST_SQX;
                end
                ST_SQX: begin
                    state_reg <= ST_SQY;
                end
                ST_SQY: begin
                    d2_reg    <= prod_reg[63:0];
                    state_reg <= ST_SQS;
                end
                ST_SQS: begin
                    d2_reg    <= d2_reg + prod_reg[63:0];
                    state_reg <= ST_PUSH;
                end
                ST_PUSH: begin
                    // edge end becomes next edge start
                    sx_reg        <= ex_reg;
                    sy_reg        <= ey_reg;
                    start_idx_reg <= j_reg[ADDR_W-1:0];
                    j_reg         <= j_inc;
                    rd_addr_reg   <= j_inc[ADDR_W-1:0];
                    drain_reg     <= '0;
                    if (j_inc == count_reg) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        state_reg <= ST_RDW;
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == 5'(ROOT_STEPS - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // running minimum at the end of the root row, first edge wins a tie
            if (chain_out.valid && root < best_reg) begin
                best_reg    <= root;
                best_si_reg <= chain_out.si;
                best_ei_reg <= chain_out.ei;
            end
        end
    end

    always_comb begin
        if (inside_reg) begin
            dist_out = 31'(-$signed({1'b0, best_reg}));
        end else begin
            dist_out = 31'(best_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            if (res_append_reg || res_status_reg != STATUS_OK) begin
                m_tdata_reg <= {3'b0, res_status_reg, 12'b0, 31'b0};
            end else begin
                m_tdata_reg <= {3'b0, res_status_reg, best_ei_reg, best_si_reg, dist_out};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond table size");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("input taken while a transaction is in work");

    a_root_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_out.valid |-> (state_reg != ST_IDLE && state_reg != ST_OUT))
        else $error("root row output outside a query");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for polygon_signed_distance_unit
// Builds a polygon transaction by transaction, queries points against it and
// checks every result against a bit-exact fixed point distance predictor,
// with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
    import psd_pkg::*;

    localparam int  TOTAL_ITEMS = 290;
    localparam int  CALM_TAIL   = 40;
    localparam int  CYCLE_LIMIT = 3000000;

    typedef logic signed [127:0] acc_t;

    typedef struct {
        logic        op;
        logic [31:0] x;
        logic [31:0] y;
        logic        drain;
    } point_item_t;

    typedef struct {
        logic [30:0] distance;
        logic [5:0]  si;
        logic [5:0]  ei;
        status_t     st;
    } dist_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    point_item_t  pending_items[$];
    dist_result_t expected_dists[$];

    acc_t vert_x[MAX_VERTICES];
    acc_t vert_y[MAX_VERTICES];
    int   vert_count = 0;

    int sent_count = 0;
    int result_count = 0;
    int err_count = 0;
    int query_count = 0;
    int inside_count = 0;
    int capped_count = 0;
    int full_count = 0;
    int src_gap = 0;
    int sink_stall = 0;
    int cycle_count = 0;
    bit drain_wait = 1'b0;

    polygon_signed_distance_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // x_coord, y_coord
        .s_tuser  (s_tuser),    // opcode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // signed_distance, start_index, end_index, status, pad
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // squared distance to one edge, Q.28 units
    function automatic acc_t edge_dist_sq(acc_t px, acc_t py, acc_t sx, acc_t sy,
                                          acc_t ex, acc_t ey);
        acc_t vx, vy, ux, uy, len2, dot, rx, ry, p;
        vx = (px - sx) >>> 2;
        vy = (py - sy) >>> 2;
        ux = (ex - sx) >>> 2;
        uy = (ey - sy) >>> 2;
        len2 = ux * ux + uy * uy;
        dot = ux * vx + uy * vy;
        if (len2 == 0 || dot <= 0) begin
            rx = vx;
            ry = vy;
        end else if (dot >= len2) begin
            rx = vx - ux;
            ry = vy - uy;
        end else begin
            p = (dot <<< 16) / len2;
            rx = vx - ((ux * p) >>> 16);
            ry = vy - ((uy * p) >>> 16);
        end
        return rx * rx + ry * ry;
    endfunction

    function automatic bit point_inside(acc_t px, acc_t py);
        bit   in;
        int   j;
        acc_t dy, lhs, rhs;
        in = 1'b0;
        j = vert_count - 1;
        for (int i = 0; i < vert_count; i++) begin
            if ((vert_y[i] > py) != (vert_y[j] > py)) begin
                dy = vert_y[j] - vert_y[i];
                lhs = (px - vert_x[i]) * dy;
                rhs = (vert_x[j] - vert_x[i]) * (py - vert_y[i]);
                if (dy > 0 ? (lhs < rhs) : (rhs < lhs)) in = ~in;
            end
            j = i;
        end
        return in;
    endfunction

    // advance the polygon model by one transaction and return its result
    function automatic dist_result_t predict_distance(point_item_t it);
        dist_result_t res;
        acc_t px, py, best, d2, len;
        int   i;
        px = acc_t'($signed(it.x));
        py = acc_t'($signed(it.y));
        res.distance = '0;
        res.si = '0;
        res.ei = '0;
        res.st = STATUS_OK;
        if (it.op == OP_APPEND) begin
            if (vert_count >= MAX_VERTICES) begin
                res.st = STATUS_FULL;
                full_count++;
            end else begin
                vert_x[vert_count] = px;
                vert_y[vert_count] = py;
                vert_count++;
            end
        end else if (vert_count == 0) begin
            res.st = STATUS_EMPTY;
        end else begin
            query_count++;
            best = acc_t'(CAP_Q16);
            res.si = 6'(vert_count - 1);
            i = vert_count - 1;
            for (int j = 0; j < vert_count; j++) begin
                d2 = edge_dist_sq(px, py, vert_x[i], vert_y[i], vert_x[j], vert_y[j]);
                if (d2 < acc_t'(CAP_SQ)) begin
                    len = acc_t'(int_sqrt(64'(d2 << 4)));
                    if (len < best) begin
                        best = len;
                        res.si = 6'(i);
                        res.ei = 6'(j);
                    end
                end
                i = j;
            end
            if (best == acc_t'(CAP_Q16)) capped_count++;
            if (point_inside(px, py)) begin
                best = -best;
                inside_count++;
            end
            res.distance = best[30:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] pick_coord(bit wide);
        if (wide) return $urandom;
        return $urandom_range(0, 26214400) - 32'd13107200;   // +-200.0
    endfunction

    task automatic add_item(logic op, logic [31:0] x, logic [31:0] y, logic drain);
        point_item_t it;
        it.op = op;
        it.x = x;
        it.y = y;
        it.drain = drain;
        pending_items = {pending_items, it};
    endtask

    // driver
    always @(posedge aclk) begin
        point_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (drain_wait && expected_dists.size() != 0) begin
                s_tvalid <= 1'b0;
            end else if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain && !drain_wait)) begin
                drain_wait <= 1'b0;
                it = pending_items.pop_front();
                s_tdata <= {it.y, it.x};
                s_tuser <= it.op;
                s_tvalid <= 1'b1;
                expected_dists = {expected_dists, predict_distance(it)};
                sent_count <= sent_count + 1;
                if (sent_count < TOTAL_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                    src_gap <= $urandom_range(1, 19);
            end else begin
                // hold off until every outstanding result is back
                if (pending_items.size() != 0) drain_wait <= 1'b1;
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        dist_result_t want;
        logic [30:0]  got_dist;
        logic [5:0]   got_si, got_ei;
        logic [1:0]   got_st;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_dist = m_tdata[30:0];
                got_si = m_tdata[36:31];
                got_ei = m_tdata[42:37];
                got_st = m_tdata[44:43];
                result_count <= result_count + 1;
                if (expected_dists.size() == 0) begin
                    err_count <= err_count + 1;
                    if (err_count < 10) $display("unexpected result %h", m_tdata);
                end else begin
                    want = expected_dists.pop_front();
                    if (got_dist !== want.distance || got_si !== want.si ||
                        got_ei !== want.ei || got_st !== want.st) begin
                        err_count <= err_count + 1;
                        if (err_count < 10)
                            $display("result %0d: expected dist %h si %0d ei %0d st %0d, got dist %h si %0d ei %0d st %0d",
                                     result_count, want.distance, want.si, want.ei, want.st,
                                     got_dist, got_si, got_ei, got_st);
                    end
                end
            end
            if (sent_count >= TOTAL_ITEMS - CALM_TAIL) begin
                m_tready <= 1'b1;
            end else if (sink_stall > 0) begin
                sink_stall <= sink_stall - 1;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                sink_stall <= $urandom_range(0, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        int appends;
        bit is_append;
        // directed: empty query, single vertex, zero-length edge, square, extremes
        add_item(OP_QUERY,  32'h0, 32'h0, 1'b0);
        add_item(OP_APPEND, 32'h0, 32'h0, 1'b0);
        add_item(OP_QUERY,  32'h7fffffff, 32'h7fffffff, 1'b0);
        add_item(OP_QUERY,  32'h00010000, 32'h00010000, 1'b0);
        add_item(OP_APPEND, 32'h0, 32'h0, 1'b0);
        add_item(OP_QUERY,  32'hfffb0000, 32'h00030000, 1'b0);
        add_item(OP_APPEND, 32'h00640000, 32'h0, 1'b0);
        add_item(OP_APPEND, 32'h00640000, 32'h00640000, 1'b0);
        add_item(OP_APPEND, 32'h0, 32'h00640000, 1'b0);
        add_item(OP_QUERY,  32'h00320000, 32'h00320000, 1'b0);
        add_item(OP_QUERY,  32'h00320000, 32'hffe20000, 1'b0);
        add_item(OP_QUERY,  32'h80000000, 32'h80000000, 1'b0);
        add_item(OP_QUERY,  32'h00640000, 32'h00640000, 1'b0);
        add_item(OP_QUERY,  32'h00320000, 32'h0, 1'b0);
        add_item(OP_QUERY,  32'hfff60000, 32'h00320000, 1'b0);
        add_item(OP_QUERY,  32'h00123456, 32'h0fedcba9, 1'b0);
        add_item(OP_APPEND, 32'h7fffffff, 32'h80000000, 1'b0);
        add_item(OP_QUERY,  32'h7fffffff, 32'h7fffffff, 1'b0);
        add_item(OP_QUERY,  32'h80000000, 32'h7fffffff, 1'b0);
        add_item(OP_QUERY,  32'h40000000, 32'hc0000000, 1'b0);
        appends = 6;
        for (int k = pending_items.size(); k < TOTAL_ITEMS; k++) begin
            is_append = ($urandom_range(0, 99) < 35);
            if (is_append) begin
                appends++;
                add_item(OP_APPEND, pick_coord($urandom_range(0, 99) < 15),
                         pick_coord($urandom_range(0, 99) < 15), k == 130);
            end else begin
                add_item(OP_QUERY, pick_coord($urandom_range(0, 99) < 15),
                         pick_coord($urandom_range(0, 99) < 15), k == 130);
            end
        end
        // make sure the table fills and overflows late in the run
        for (int k = appends; k < MAX_VERTICES + 3; k++)
            add_item(OP_APPEND, pick_coord(1'b0), pick_coord(1'b0), 1'b0);
        add_item(OP_QUERY, pick_coord(1'b0), pick_coord(1'b0), 1'b0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_items.size() == 0 && !s_tvalid && expected_dists.size() == 0);
        repeat (200) @(posedge aclk);
        $display("covered %0d transactions: %0d polygon queries (%0d inside, %0d capped)",
                 sent_count, query_count, inside_count, capped_count);
        $display("table filled to %0d vertices, %0d appends rejected as full",
                 vert_count, full_count);
        if (err_count == 0 && expected_dists.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches", err_count);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
